>>> src/hmfe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmfe_pkg
// Shared types and constants of the hash map with FIFO eviction.
// ---------------------------------------------------------------------------
package hmfe_pkg;

	localparam logic [31:0] HASH_SEED = 32'd19780211;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned VAL_W = 64;
	localparam int unsigned LEN_W = 4;
	localparam int unsigned HASH_W = 32;
	localparam int unsigned LIMIT_W = 6;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	typedef enum logic [1:0] {
		MODE_PUT    = 2'd0,
		MODE_GET    = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [KEY_W-1:0]   key;
		logic [LEN_W-1:0]   len;
		logic [VAL_W-1:0]   value;
		logic [HASH_W-1:0]  hash;
	} item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [4:0] {
		B_CLR,
		B_IDLE,
		B_HEAD,
		B_FIRST,
		B_WALK,
		B_EVCHK,
		B_RM_RD,
		B_RM_HEAD,
		B_RM_BH,
		B_RM_WALK,
		B_RM_LINK,
		B_EV_OUT,
		B_ALLOC,
		B_ALLOC_W,
		B_INS_RD,
		B_INS_WR,
		B_INS_LNK,
		B_FIN
	} back_state_t;

endpackage

>>> src/hash_map_fifo_evict_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hash_map_fifo_evict_unit
// Key-value store with hashed chained buckets and oldest-first eviction.
// ---------------------------------------------------------------------------
// Use: write entry_limit on the cfg channel while idle. Send operations on
// the in channel (put, get, lookup-or-insert, delete). Each operation gives
// zero or more eviction reports (is_eviction 1) followed by one final result
// with last set, all on the out channel.
// Flow: the front hashes the key a byte at a time and then picks the
// bucket, then queues the transaction. The back reads the bucket head and
// walks the chain to look up, reads the entry and walks to its predecessor
// per removal or eviction, allocates, writes and links a slot to insert,
// and then loads the result. The front takes a new operation only once it
// has queued the last one; the back may be the slower side when long chain
// walks or evictions occur, and then the queue absorbs the gap.
// Reset: bucket heads are cleared one after another after reset; in_ready
// stays low until then. Configuration writes are taken at any time.
// A stalled receiver holds the result register and the back waits; the
// two-entry queue then fills and in_ready drops.
// ---------------------------------------------------------------------------
module hash_map_fifo_evict_unit
	import hmfe_pkg::*;
#(
	parameter int unsigned CAPACITY  = 32,
	parameter int unsigned BUCKETS   = 16,
	parameter int unsigned KEY_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [LIMIT_W-1:0]            cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [KEY_W-1:0]              key,
	input  logic [LEN_W-1:0]              key_len,
	input  logic [VAL_W-1:0]              value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_eviction,
	output logic                          found,
	output logic [VAL_W-1:0]              value_out,
	output logic [KEY_W-1:0]              key_out,
	output logic [LEN_W-1:0]              key_len_out,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                          last
);

	localparam int unsigned BW = $clog2(BUCKETS);
	localparam int unsigned QW = $bits(item_t) + BW;

	logic [LIMIT_W-1:0] entry_limit_q;
	logic               enable;
	logic               push, q_full, q_pop, q_valid;
	item_t              f_item, q_item;
	logic [BW-1:0]      f_bucket, q_bucket;
	logic [QW-1:0]      q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			entry_limit_q <= cfg_data;
		end
	end

	hmfe_front #(.BUCKETS(BUCKETS), .KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .enable(enable),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .key(key), .key_len(key_len), .value(value),
		.push(push), .push_item(f_item), .push_bucket(f_bucket),
		.queue_full(q_full));

	hmfe_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data({f_item, f_bucket}), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .pop_data(q_data));

	assign q_item   = q_data[QW-1:BW];
	assign q_bucket = q_data[BW-1:0];

	hmfe_back #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_back (
		.clk(clk), .arst_n(arst_n), .entry_limit(entry_limit_q),
		.ready_for_items(enable),
		.q_valid(q_valid), .q_item(q_item), .q_bucket(q_bucket), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_eviction(is_eviction), .found(found), .value_out(value_out),
		.key_out(key_out), .key_len_out(key_len_out),
		.entry_count(entry_count), .last(last));

endmodule

>>> src/hmfe_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmfe_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module hmfe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/hmfe_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmfe_queue
// Two-entry queue between the classifying front and the executing back.
// ---------------------------------------------------------------------------
module hmfe_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

>>> src/hmfe_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmfe_front
// Accepts a transaction, cleans the key, hashes it a byte per cycle and
// reduces the hash to a bucket eight bits per cycle.
// ---------------------------------------------------------------------------
module hmfe_front
	import hmfe_pkg::*;
#(
	parameter int unsigned BUCKETS   = 16,
	parameter int unsigned KEY_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 mode,
	input  logic [KEY_W-1:0]           key,
	input  logic [LEN_W-1:0]           key_len,
	input  logic [VAL_W-1:0]           value,
	output logic                       push,
	output item_t                      push_item,
	output logic [$clog2(BUCKETS)-1:0] push_bucket,
	input  logic                       queue_full
);

	localparam int unsigned BW = $clog2(BUCKETS);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_BYTES);

	front_state_t      state_q, state_d;
	item_t             item_q;
	logic [3:0]        idx_q;
	logic [1:0]        step_q;
	logic [HASH_W-1:0] hs_q;
	logic [BW-1:0]     rem_q;

	logic [LEN_W-1:0]  len_c;
	logic [KEY_W-1:0]  key_c;
	logic [HASH_W-1:0] hash_nxt;
	logic [BW-1:0]     rem_nxt;
	logic [BW:0]       t;
	logic              accept;

	always_comb begin
		len_c = (key_len > MAX_LEN) ? MAX_LEN : key_len;
		for (int i = 0; i < 8; i++) begin
			key_c[8*i +: 8] = (LEN_W'(i) < len_c) ? key[8*i +: 8] : 8'd0;
		end
	end

	assign hash_nxt = item_q.hash * HASH_SEED
		+ {24'd0, item_q.key[{idx_q[2:0], 3'b000} +: 8]};

	// restoring remainder, eight hash bits per cycle
	always_comb begin
		rem_nxt = rem_q;
		t = '0;
		for (int j = 0; j < 8; j++) begin
			t = {rem_nxt, hs_q[31-j]};
			if (t >= (BW+1)'(BUCKETS)) begin
				t = t - (BW+1)'(BUCKETS);
			end
			rem_nxt = t[BW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_HASH;
			F_HASH: if (idx_q == item_q.len) state_d = F_MOD;
			F_MOD:  if (step_q == 2'd3) state_d = F_PUSH;
			F_PUSH: if (!queue_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE) && enable;
		push     = (state_q == F_PUSH) && !queue_full;
	end

	assign accept      = in_valid && in_ready;
	assign push_item   = item_q;
	assign push_bucket = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					item_q.mode  <= mode_t'(mode);
					item_q.key   <= key_c;
					item_q.len   <= len_c;
					item_q.value <= value;
					item_q.hash  <= '0;
					idx_q        <= '0;
				end
			end
			F_HASH: begin
				if (idx_q == item_q.len) begin
					hs_q   <= item_q.hash;
					rem_q  <= '0;
					step_q <= '0;
				end else begin
					item_q.hash <= hash_nxt;
					idx_q       <= idx_q + 4'd1;
				end
			end
			F_MOD: begin
				rem_q  <= rem_nxt;
				hs_q   <= {hs_q[23:0], 8'd0};
				step_q <= step_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/hmfe_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmfe_back
// Walks bucket chains, updates, removes, evicts and inserts entries and
// delivers the results through one output register.
// ---------------------------------------------------------------------------
module hmfe_back
	import hmfe_pkg::*;
#(
	parameter int unsigned CAPACITY = 32,
	parameter int unsigned BUCKETS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [LIMIT_W-1:0]            entry_limit,
	output logic                          ready_for_items,
	input  logic                          q_valid,
	input  item_t                         q_item,
	input  logic [$clog2(BUCKETS)-1:0]    q_bucket,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_eviction,
	output logic                          found,
	output logic [VAL_W-1:0]              value_out,
	output logic [KEY_W-1:0]              key_out,
	output logic [LEN_W-1:0]              key_len_out,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                          last
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned BW = $clog2(BUCKETS);
	localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int unsigned RW = KEY_W + LEN_W + HASH_W + BW;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	back_state_t state_q, state_d;

	// current item
	mode_t             mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [VAL_W-1:0]  val_q;
	logic [HASH_W-1:0] hash_q;
	logic [BW-1:0]     bkt_q;

	logic [PW-1:0]     cur_q;
	logic [AW-1:0]     e_q;
	logic [AW-1:0]     p_q;
	logic [AW-1:0]     slot_q;
	logic              evict_q;
	logic [BW-1:0]     ebkt_q;
	logic [PW-1:0]     enext_q, eold_q, enew_q;
	logic [KEY_W-1:0]  evkey_q;
	logic [LEN_W-1:0]  evlen_q;
	logic [VAL_W-1:0]  evval_q;
	logic              fin_found_q;
	logic [VAL_W-1:0]  fin_val_q;

	logic [PW-1:0]     oldest_q, newest_q;
	logic [CW-1:0]     count_q, sp_q, hw_q;
	logic [BW-1:0]     clr_q;

	logic              out_valid_q;

	// memories
	logic rec_we, val_we, chn_we, old_we, new_we, bh_we, fr_we;
	logic [AW-1:0] rec_waddr, val_waddr, chn_waddr, old_waddr, new_waddr, fr_waddr;
	logic [AW-1:0] rec_raddr, chn_raddr, fr_raddr;
	logic [BW-1:0] bh_waddr, bh_raddr;
	logic [RW-1:0] rec_wdata, rec_rdata;
	logic [VAL_W-1:0] val_wdata, val_rdata;
	logic [PW-1:0] chn_wdata, chn_rdata, old_wdata, old_rdata, new_wdata, new_rdata;
	logic [PW-1:0] bh_wdata, bh_rdata;
	logic [AW-1:0] fr_wdata, fr_rdata;

	logic [KEY_W-1:0]  rec_key;
	logic [LEN_W-1:0]  rec_len;
	logic [HASH_W-1:0] rec_hash;
	logic [BW-1:0]     rec_bkt;

	logic              rec_match;
	logic              slot_free;
	logic              evict_go;
	logic [LW-1:0]     lim;
	logic [VAL_W-1:0]  ins_val;
	back_state_t       miss_next;

	assign rec_bkt  = rec_rdata[BW-1:0];
	assign rec_hash = rec_rdata[BW +: HASH_W];
	assign rec_len  = rec_rdata[BW+HASH_W +: LEN_W];
	assign rec_key  = rec_rdata[BW+HASH_W+LEN_W +: KEY_W];

	assign rec_match = (rec_hash == hash_q) && (rec_len == len_q) && (rec_key == key_q);
	assign slot_free = !out_valid_q || out_ready;
	assign ins_val   = (mode_q == MODE_PUT) ? val_q : '0;
	assign miss_next = (mode_q == MODE_GET || mode_q == MODE_DELETE) ? B_FIN : B_EVCHK;

	// effective limit: zero acts as one, above capacity acts as capacity
	always_comb begin
		lim = LW'(entry_limit);
		if (lim == '0) begin
			lim = LW'(1);
		end
		if (lim > LW'(CAPACITY)) begin
			lim = LW'(CAPACITY);
		end
	end

	assign evict_go = (LW'(count_q) >= lim) && (oldest_q != NIL);

	hmfe_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rdata));
	hmfe_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(rec_raddr), .rdata(val_rdata));
	hmfe_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_chn (
		.clk(clk), .we(chn_we), .waddr(chn_waddr), .wdata(chn_wdata),
		.raddr(chn_raddr), .rdata(chn_rdata));
	hmfe_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_old (
		.clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
		.raddr(e_q), .rdata(old_rdata));
	hmfe_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_new (
		.clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
		.raddr(e_q), .rdata(new_rdata));
	hmfe_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bh (
		.clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
		.raddr(bh_raddr), .rdata(bh_rdata));
	hmfe_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_fr (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLR:     if (clr_q == BW'(BUCKETS - 1)) state_d = B_IDLE;
			B_IDLE:    if (q_valid) state_d = B_HEAD;
			B_HEAD:    state_d = B_FIRST;
			B_FIRST:   state_d = (bh_rdata == NIL) ? miss_next : B_WALK;
			B_WALK: begin
				if (rec_match) begin
					state_d = (mode_q == MODE_DELETE) ? B_RM_RD : B_FIN;
				end else if (chn_rdata == NIL) begin
					state_d = miss_next;
				end
			end
			B_EVCHK:   state_d = evict_go ? B_RM_RD : B_ALLOC;
			B_RM_RD:   state_d = B_RM_HEAD;
			B_RM_HEAD: state_d = B_RM_BH;
			B_RM_BH:   state_d = (bh_rdata == {1'b0, e_q}) ? B_RM_LINK : B_RM_WALK;
			B_RM_WALK: if (chn_rdata == {1'b0, e_q}) state_d = B_RM_LINK;
			B_RM_LINK: state_d = evict_q ? B_EV_OUT : B_FIN;
			B_EV_OUT:  if (slot_free) state_d = B_EVCHK;
			B_ALLOC:   state_d = (sp_q != '0) ? B_ALLOC_W : B_INS_RD;
			B_ALLOC_W: state_d = B_INS_RD;
			B_INS_RD:  state_d = B_INS_WR;
			B_INS_WR:  state_d = B_INS_LNK;
			B_INS_LNK: state_d = B_FIN;
			B_FIN:     if (slot_free) state_d = B_IDLE;
			default:   state_d = B_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		rec_we = 1'b0; val_we = 1'b0; chn_we = 1'b0; old_we = 1'b0;
		new_we = 1'b0; bh_we = 1'b0; fr_we = 1'b0;
		rec_waddr = slot_q;
		rec_wdata = {key_q, len_q, hash_q, bkt_q};
		val_waddr = slot_q;
		val_wdata = ins_val;
		chn_waddr = slot_q;
		chn_wdata = bh_rdata;
		old_waddr = slot_q;
		old_wdata = newest_q;
		new_waddr = slot_q;
		new_wdata = NIL;
		bh_waddr  = bkt_q;
		bh_wdata  = {1'b0, slot_q};
		fr_waddr  = sp_q[AW-1:0];
		fr_wdata  = e_q;
		rec_raddr = e_q;
		chn_raddr = e_q;
		bh_raddr  = bkt_q;
		fr_raddr  = AW'(sp_q - CW'(1));
		q_pop     = 1'b0;
		unique case (state_q)
			B_CLR: begin
				bh_we    = 1'b1;
				bh_waddr = clr_q;
				bh_wdata = NIL;
			end
			B_IDLE: q_pop = q_valid;
			B_FIRST: begin
				rec_raddr = bh_rdata[AW-1:0];
				chn_raddr = bh_rdata[AW-1:0];
			end
			B_WALK: begin
				rec_raddr = chn_rdata[AW-1:0];
				chn_raddr = chn_rdata[AW-1:0];
				if (rec_match && mode_q == MODE_PUT) begin
					val_we    = 1'b1;
					val_waddr = cur_q[AW-1:0];
					val_wdata = val_q;
				end
			end
			B_RM_HEAD: bh_raddr = rec_bkt;
			B_RM_BH: begin
				chn_raddr = bh_rdata[AW-1:0];
				if (bh_rdata == {1'b0, e_q}) begin
					bh_we    = 1'b1;
					bh_waddr = ebkt_q;
					bh_wdata = enext_q;
				end
			end
			B_RM_WALK: begin
				chn_raddr = chn_rdata[AW-1:0];
				if (chn_rdata == {1'b0, e_q}) begin
					chn_we    = 1'b1;
					chn_waddr = p_q;
					chn_wdata = enext_q;
				end
			end
			B_RM_LINK: begin
				new_we    = (eold_q != NIL);
				new_waddr = eold_q[AW-1:0];
				new_wdata = enew_q;
				old_we    = (enew_q != NIL);
				old_waddr = enew_q[AW-1:0];
				old_wdata = eold_q;
				fr_we     = 1'b1;
			end
			B_INS_WR: begin
				rec_we = 1'b1;
				val_we = 1'b1;
				chn_we = 1'b1;
				bh_we  = 1'b1;
				old_we = 1'b1;
				new_we = 1'b1;
			end
			B_INS_LNK: begin
				new_we    = (newest_q != NIL);
				new_waddr = newest_q[AW-1:0];
				new_wdata = {1'b0, slot_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			oldest_q    <= NIL;
			newest_q    <= NIL;
			count_q     <= '0;
			sp_q        <= '0;
			hw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// load a result when the register frees up, drop it once taken
			if ((state_q == B_EV_OUT || state_q == B_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLR: clr_q <= clr_q + BW'(1);
				B_RM_LINK: begin
					if (newest_q == {1'b0, e_q}) newest_q <= eold_q;
					if (oldest_q == {1'b0, e_q}) oldest_q <= enew_q;
					sp_q    <= sp_q + CW'(1);
					count_q <= count_q - CW'(1);
				end
				B_ALLOC: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - CW'(1);
					end else begin
						hw_q <= hw_q + CW'(1);
					end
				end
				B_INS_LNK: begin
					if (newest_q == NIL) oldest_q <= {1'b0, slot_q};
					newest_q <= {1'b0, slot_q};
					count_q  <= count_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					mode_q  <= q_item.mode;
					key_q   <= q_item.key;
					len_q   <= q_item.len;
					val_q   <= q_item.value;
					hash_q  <= q_item.hash;
					bkt_q   <= q_bucket;
					evict_q <= 1'b0;
				end
			end
			B_FIRST: begin
				cur_q       <= bh_rdata;
				fin_found_q <= 1'b0;
				fin_val_q   <= '0;
			end
			B_WALK: begin
				if (rec_match) begin
					e_q         <= cur_q[AW-1:0];
					fin_found_q <= 1'b1;
					fin_val_q   <= (mode_q == MODE_PUT) ? val_q : val_rdata;
				end else begin
					cur_q <= chn_rdata;
				end
			end
			B_EVCHK: begin
				if (evict_go) begin
					e_q     <= oldest_q[AW-1:0];
					evict_q <= 1'b1;
				end
			end
			B_RM_HEAD: begin
				ebkt_q  <= rec_bkt;
				evkey_q <= rec_key;
				evlen_q <= rec_len;
				evval_q <= val_rdata;
				enext_q <= chn_rdata;
				eold_q  <= old_rdata;
				enew_q  <= new_rdata;
			end
			B_RM_BH:   p_q <= bh_rdata[AW-1:0];
			B_RM_WALK: p_q <= chn_rdata[AW-1:0];
			B_ALLOC:   if (sp_q == '0) slot_q <= hw_q[AW-1:0];
			B_ALLOC_W: slot_q <= fr_rdata;
			B_INS_WR: begin
				fin_found_q <= 1'b0;
				fin_val_q   <= ins_val;
			end
			B_EV_OUT: begin
				if (slot_free) begin
					is_eviction <= 1'b1;
					found       <= 1'b1;
					value_out   <= evval_q;
					key_out     <= evkey_q;
					key_len_out <= evlen_q;
					entry_count <= count_q;
					last        <= 1'b0;
				end
			end
			B_FIN: begin
				if (slot_free) begin
					is_eviction <= 1'b0;
					found       <= fin_found_q;
					value_out   <= fin_val_q;
					key_out     <= '0;
					key_len_out <= '0;
					entry_count <= count_q;
					last        <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign ready_for_items = (state_q != B_CLR);

	// every slot handed out is either stored or on the free stack
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> (hw_q - sp_q == count_q))
		else $error("slot accounting broken");

	a_fifo_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> ((oldest_q == NIL) == (count_q == '0)))
		else $error("age list and count disagree");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ALLOC && sp_q == '0) |-> (hw_q < CW'(CAPACITY)))
		else $error("allocation with no free slot");

endmodule
